// ===== hw/rtl/dual_zone_fridge_controller_macros.svh =====
// assertion macros for the dual zone fridge controller
// used by the top level; no other dependencies
`ifndef DUAL_ZONE_FRIDGE_CONTROLLER_MACROS_SVH
`define DUAL_ZONE_FRIDGE_CONTROLLER_MACROS_SVH

// same cycle implication, disabled in reset
`define DZFC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next cycle implication, disabled in reset
`define DZFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/dzfc_pkg.sv =====
// types, codes and reset values for the dual zone fridge controller
// no dependencies; used by dzfc_step and the top level
`timescale 1ns / 1ps

package dzfc_pkg;

  localparam int TEMP_W  = 12;
  localparam int COUNT_W = 16;
  localparam int BAND_W  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // event kinds
  localparam logic [1:0] FUNC_DOOR = 2'd0;
  localparam logic [1:0] FUNC_KEY  = 2'd1;
  localparam logic [1:0] FUNC_COMP = 2'd2;

  // key codes
  localparam logic [2:0] BTN_FRIDGE_UP   = 3'd1;
  localparam logic [2:0] BTN_FRIDGE_DN   = 3'd2;
  localparam logic [2:0] BTN_FREEZER_UP  = 3'd3;
  localparam logic [2:0] BTN_FREEZER_DN  = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HYST_BAND   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_TICKS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRIDGE_MAX  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRIDGE_MIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FREEZER_MAX = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FREEZER_MIN = 3'd6;

  localparam logic [BAND_W-1:0]         HYST_BAND_RST   = 8'd5;
  localparam logic [COUNT_W-1:0]        ALARM_TICKS_RST = 16'd600;
  localparam logic [COUNT_W-1:0]        CUTOFF_RST      = 16'd6000;
  localparam logic signed [TEMP_W-1:0]  FRIDGE_MAX_RST  = 12'sd100;
  localparam logic signed [TEMP_W-1:0]  FRIDGE_MIN_RST  = 12'sd0;
  localparam logic signed [TEMP_W-1:0]  FREEZER_MAX_RST = -12'sd80;
  localparam logic signed [TEMP_W-1:0]  FREEZER_MIN_RST = -12'sd220;
  localparam logic signed [TEMP_W-1:0]  FRIDGE_TGT_RST  = 12'sd40;
  localparam logic signed [TEMP_W-1:0]  FREEZER_TGT_RST = -12'sd180;

  typedef struct packed {
    logic [BAND_W-1:0]        hysteresis_band;
    logic [COUNT_W-1:0]       alarm_ticks;
    logic [COUNT_W-1:0]       cutoff_ticks;
    logic signed [TEMP_W-1:0] fridge_set_max;
    logic signed [TEMP_W-1:0] fridge_set_min;
    logic signed [TEMP_W-1:0] freezer_set_max;
    logic signed [TEMP_W-1:0] freezer_set_min;
  } cfg_t;

  typedef struct packed {
    logic                     fridge_running;
    logic                     freezer_running;
    logic [COUNT_W-1:0]       open_count;
    logic                     alarm_active;
    logic                     lockout;
    logic signed [TEMP_W-1:0] fridge_target;
    logic signed [TEMP_W-1:0] freezer_target;
  } state_t;

  typedef struct packed {
    logic [1:0]               func;
    logic                     door_open;
    logic [2:0]               button;
    logic signed [TEMP_W-1:0] fridge_temp;
    logic signed [TEMP_W-1:0] freezer_temp;
  } item_t;

  typedef struct packed {
    logic                     fridge_relay;
    logic                     freezer_relay;
    logic                     buzzer_on;
    logic                     warning_lamp;
    logic                     compressor_lock;
    logic signed [TEMP_W-1:0] fridge_setpoint;
    logic signed [TEMP_W-1:0] freezer_setpoint;
    logic                     display_refresh;
  } result_t;

endpackage

// ===== hw/rtl/dzfc_step.sv =====
// next state and result for one controller event
// depends on dzfc_pkg
`timescale 1ns / 1ps

module dzfc_step (
  input  dzfc_pkg::cfg_t    cfg,
  input  dzfc_pkg::state_t  st,
  input  dzfc_pkg::item_t   item,
  output dzfc_pkg::state_t  st_next,
  output dzfc_pkg::result_t result
);

  localparam int WIDE_W = dzfc_pkg::TEMP_W + 2;

  logic [dzfc_pkg::COUNT_W-1:0] count_inc;
  logic                         refresh;
  logic signed [WIDE_W-1:0]     band_w;
  logic signed [WIDE_W-1:0]     f_tgt_w;
  logic signed [WIDE_W-1:0]     z_tgt_w;
  logic signed [WIDE_W-1:0]     f_temp_w;
  logic signed [WIDE_W-1:0]     z_temp_w;
  logic                         f_run_hyst;
  logic                         z_run_hyst;

  assign count_inc = (st.open_count != {dzfc_pkg::COUNT_W{1'b1}}) ?
                     st.open_count + 1'b1 : st.open_count;

  assign band_w   = $signed({{(WIDE_W-dzfc_pkg::BAND_W){1'b0}}, cfg.hysteresis_band});
  assign f_tgt_w  = WIDE_W'(st.fridge_target);
  assign z_tgt_w  = WIDE_W'(st.freezer_target);
  assign f_temp_w = WIDE_W'(item.fridge_temp);
  assign z_temp_w = WIDE_W'(item.freezer_temp);

  // bang-bang with band around the target
  always_comb begin
    f_run_hyst = st.fridge_running;
    if (!st.fridge_running && (f_temp_w > f_tgt_w + band_w)) begin
      f_run_hyst = 1'b1;
    end else if (st.fridge_running && (f_temp_w < f_tgt_w - band_w)) begin
      f_run_hyst = 1'b0;
    end
    z_run_hyst = st.freezer_running;
    if (!st.freezer_running && (z_temp_w > z_tgt_w + band_w)) begin
      z_run_hyst = 1'b1;
    end else if (st.freezer_running && (z_temp_w < z_tgt_w - band_w)) begin
      z_run_hyst = 1'b0;
    end
  end

  always_comb begin
    st_next = st;
    refresh = 1'b0;
    case (item.func)
      dzfc_pkg::FUNC_DOOR: begin
        if (item.door_open) begin
          st_next.open_count = count_inc;
          if (count_inc > cfg.alarm_ticks) begin
            st_next.alarm_active = 1'b1;
          end
          if (count_inc > cfg.cutoff_ticks) begin
            st_next.lockout = 1'b1;
          end
        end else begin
          st_next.open_count   = '0;
          st_next.alarm_active = 1'b0;
          st_next.lockout      = 1'b0;
        end
      end
      dzfc_pkg::FUNC_KEY: begin
        case (item.button)
          dzfc_pkg::BTN_FRIDGE_UP: begin
            if (st.fridge_target < cfg.fridge_set_max) begin
              st_next.fridge_target = st.fridge_target + 12'sd1;
              refresh = 1'b1;
            end
          end
          dzfc_pkg::BTN_FRIDGE_DN: begin
            if (st.fridge_target > cfg.fridge_set_min) begin
              st_next.fridge_target = st.fridge_target - 12'sd1;
              refresh = 1'b1;
            end
          end
          dzfc_pkg::BTN_FREEZER_UP: begin
            if (st.freezer_target < cfg.freezer_set_max) begin
              st_next.freezer_target = st.freezer_target + 12'sd1;
              refresh = 1'b1;
            end
          end
          dzfc_pkg::BTN_FREEZER_DN: begin
            if (st.freezer_target > cfg.freezer_set_min) begin
              st_next.freezer_target = st.freezer_target - 12'sd1;
              refresh = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      dzfc_pkg::FUNC_COMP: begin
        if (st.lockout) begin
          st_next.fridge_running  = 1'b0;
          st_next.freezer_running = 1'b0;
        end else begin
          st_next.fridge_running  = f_run_hyst;
          st_next.freezer_running = z_run_hyst;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result.fridge_relay     = st_next.fridge_running;
    result.freezer_relay    = st_next.freezer_running;
    result.buzzer_on        = st_next.alarm_active;
    result.warning_lamp     = st_next.alarm_active;
    result.compressor_lock  = st_next.lockout;
    result.fridge_setpoint  = st_next.fridge_target;
    result.freezer_setpoint = st_next.freezer_target;
    result.display_refresh  = refresh;
  end

endmodule

// ===== hw/rtl/dual_zone_fridge_controller.sv =====
// dual zone fridge controller top level: config registers, state, result register
// depends on dzfc_pkg, dzfc_step and dual_zone_fridge_controller_macros.svh
//
//   channel | dir | signals                        | content
//   s       | in  | s_tvalid s_tready s_tdata s_tuser | one event request
//   m       | out | m_tvalid m_tready m_tdata     | one result per event
//   cfg     | in  | cfg_we cfg_index cfg_data      | register write
//
// one request per cycle while s_tready is high; the result is registered and appears in the cycle after acceptance
// the state update is a single compare and increment pass from input to register
// s_tready drops only while a result waits and m_tready is low
// synchronous reset loads the state and config reset values and clears m_tvalid
`timescale 1ns / 1ps
`include "dual_zone_fridge_controller_macros.svh"

module dual_zone_fridge_controller (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // door_open[0], button[3:1], fridge_temp[15:4], freezer_temp[27:16]
  input  logic [31:0]                       s_tdata,
  // func[1:0]
  input  logic [1:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // fridge_relay[0], freezer_relay[1], buzzer_on[2], warning_lamp[3],
  // compressor_lock[4], fridge_setpoint[16:5], freezer_setpoint[28:17],
  // display_refresh[29]
  output logic [31:0]                       m_tdata,
  input  logic                              cfg_we,
  input  logic [dzfc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dzfc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  dzfc_pkg::cfg_t    cfg;
  dzfc_pkg::state_t  st;
  dzfc_pkg::state_t  st_next;
  dzfc_pkg::item_t   item;
  dzfc_pkg::result_t result_next;
  dzfc_pkg::result_t result;
  logic              accept;
  logic              acc_comp_lock;
  logic              acc_door_shut;
  logic              acc_other;
  logic              relays_off;
  logic              door_clear;
  logic              plain_out;
  logic              lock_agrees;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign item.func         = s_tuser;
  assign item.door_open    = s_tdata[0];
  assign item.button       = s_tdata[3:1];
  assign item.fridge_temp  = s_tdata[15:4];
  assign item.freezer_temp = s_tdata[27:16];

  dzfc_step u_step (
    .cfg     (cfg),
    .st      (st),
    .item    (item),
    .st_next (st_next),
    .result  (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hysteresis_band <= dzfc_pkg::HYST_BAND_RST;
      cfg.alarm_ticks     <= dzfc_pkg::ALARM_TICKS_RST;
      cfg.cutoff_ticks    <= dzfc_pkg::CUTOFF_RST;
      cfg.fridge_set_max  <= dzfc_pkg::FRIDGE_MAX_RST;
      cfg.fridge_set_min  <= dzfc_pkg::FRIDGE_MIN_RST;
      cfg.freezer_set_max <= dzfc_pkg::FREEZER_MAX_RST;
      cfg.freezer_set_min <= dzfc_pkg::FREEZER_MIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        dzfc_pkg::REG_HYST_BAND:   cfg.hysteresis_band <= cfg_data[dzfc_pkg::BAND_W-1:0];
        dzfc_pkg::REG_ALARM_TICKS: cfg.alarm_ticks     <= cfg_data;
        dzfc_pkg::REG_CUTOFF:      cfg.cutoff_ticks    <= cfg_data;
        dzfc_pkg::REG_FRIDGE_MAX:  cfg.fridge_set_max  <= cfg_data[dzfc_pkg::TEMP_W-1:0];
        dzfc_pkg::REG_FRIDGE_MIN:  cfg.fridge_set_min  <= cfg_data[dzfc_pkg::TEMP_W-1:0];
        dzfc_pkg::REG_FREEZER_MAX: cfg.freezer_set_max <= cfg_data[dzfc_pkg::TEMP_W-1:0];
        dzfc_pkg::REG_FREEZER_MIN: cfg.freezer_set_min <= cfg_data[dzfc_pkg::TEMP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.fridge_running  <= 1'b0;
      st.freezer_running <= 1'b0;
      st.open_count      <= '0;
      st.alarm_active    <= 1'b0;
      st.lockout         <= 1'b0;
      st.fridge_target   <= dzfc_pkg::FRIDGE_TGT_RST;
      st.freezer_target  <= dzfc_pkg::FREEZER_TGT_RST;
    end else if (accept) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  assign m_tdata = {2'b00,
                    result.display_refresh,
                    result.freezer_setpoint,
                    result.fridge_setpoint,
                    result.compressor_lock,
                    result.warning_lamp,
                    result.buzzer_on,
                    result.freezer_relay,
                    result.fridge_relay};

  assign acc_comp_lock = accept && (s_tuser == dzfc_pkg::FUNC_COMP) && st.lockout;
  assign acc_door_shut = accept && (s_tuser == dzfc_pkg::FUNC_DOOR) && !s_tdata[0];
  assign acc_other     = accept && (s_tuser != dzfc_pkg::FUNC_KEY);
  assign relays_off    = !st.fridge_running && !st.freezer_running;
  assign door_clear    = (st.open_count == '0) && !st.alarm_active && !st.lockout;
  assign plain_out     = m_tvalid && !result.display_refresh;
  assign lock_agrees   = (result.compressor_lock == st.lockout) || !s_tready;

  `DZFC_ASSERT_NEXT(a_lock_stops_relays, clk, rst, acc_comp_lock, relays_off, "relays on in lock")
  `DZFC_ASSERT_NEXT(a_door_close_clears, clk, rst, acc_door_shut, door_clear, "door state kept")
  `DZFC_ASSERT_NEXT(a_refresh_key_only, clk, rst, acc_other, plain_out, "stray refresh")
  `DZFC_ASSERT_NOW(a_result_matches_state, clk, rst, m_tvalid, lock_agrees, "lock out of step")

endmodule
